>>> design/event_timer_table_assert.svh
// Assertion macros for the timer table; clk and rst_n are taken from the enclosing module.
`ifndef EVENT_TIMER_TABLE_ASSERT_SVH
`define EVENT_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication.
`define ETT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("event_timer_table: assertion failed");

// Next-cycle implication.
`define ETT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("event_timer_table: assertion failed");

`endif

>>> design/ett_pkg.sv
`timescale 1ns / 1ps

package ett_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int CNT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TAG_W     = 16;
  localparam int TIME_W    = 64;
  localparam int SLOT_W    = 3;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              armed;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] period;
  } slot_t;

  typedef enum logic [1:0] {
    OP_REG   = 2'd0,
    OP_UNREG = 2'd1,
    OP_SCHED = 2'd2,
    OP_PROC  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Report a slot index in the fixed 3-bit result field.
  function automatic logic [SLOT_W-1:0] slot_code(input logic [CNT_W-1:0] idx);
    logic [CNT_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

>>> design/ett_cell.sv
`timescale 1ns / 1ps

module ett_cell import ett_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift,
  input  slot_t d_in,
  output slot_t q
);

  logic [TAG_W-1:0]  tag_r;
  logic              armed_r;
  logic [TIME_W-1:0] due_r;
  logic [TIME_W-1:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      armed_r <= 1'b0;
    end else if (shift) begin
      tag_r   <= d_in.tag;
      armed_r <= d_in.armed;
    end
  end

  // Due time and period only matter once a slot is armed, which writes both.
  always_ff @(posedge clk) begin
    if (shift) begin
      due_r    <= d_in.due;
      period_r <= d_in.period;
    end
  end

  assign q = '{tag: tag_r, armed: armed_r, due: due_r, period: period_r};

endmodule

>>> design/event_timer_table.sv
`timescale 1ns / 1ps

// Channel   Ports                                            Handshake
// input     in_op in_event_id in_time_req in_interval        start high, busy low
// result    out_kind out_ok out_slot out_fired_id             out_valid for one cycle
//           out_fire_time out_last
//
// Each word holds busy while the ring of slot cells rotates once, one slot passing the head
// update per cycle, and then in a closing state for the status or closing result. The final
// result shows in the first idle cycle, where the next word may be taken. Fired results leave
// in the cycle after their slot passes the head. Synchronous reset empties and disarms every
// slot. Results cannot be stalled.

`include "event_timer_table_assert.svh"

module event_timer_table import ett_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [TAG_W-1:0]  in_event_id,
  input  logic [TIME_W-1:0] in_time_req,
  input  logic [TIME_W-1:0] in_interval,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic              out_ok,
  output logic [SLOT_W-1:0] out_slot,
  output logic [TAG_W-1:0]  out_fired_id,
  output logic [TIME_W-1:0] out_fire_time,
  output logic              out_last
);

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_SLOTS - 1);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r;
  logic              found_r, found_nxt;
  logic [CNT_W-1:0]  first_r, first_nxt;
  op_t               op_r;
  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] iv_r;

  logic              out_valid_r, ov_nxt;
  kind_t             out_kind_r, kind_nxt;
  logic              out_ok_r, ok_nxt;
  logic [SLOT_W-1:0] out_slot_r, slot_nxt;
  logic [TAG_W-1:0]  out_id_r, id_nxt;
  logic [TIME_W-1:0] out_ft_r, ft_nxt;
  logic              out_last_r, last_nxt;

  logic  accept;
  logic  cell_shift;
  logic  tag_nz, time_nz, head_match, head_due;
  slot_t head_upd;
  slot_t cell_q [NUM_SLOTS];

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign cell_shift = (state_r == ST_SCAN);
  assign tag_nz     = (tag_r != '0);
  assign time_nz    = (time_r != '0);
  assign head_match = (cell_q[0].tag == tag_r);
  assign head_due   = (cell_q[0].tag != '0) && cell_q[0].armed && (cell_q[0].due <= time_r);

  // Ring of slot cells: the head updates and returns to the tail.
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    slot_t cell_d;
    if (k == NUM_SLOTS - 1) begin : g_tail
      assign cell_d = head_upd;
    end else begin : g_mid
      assign cell_d = cell_q[k+1];
    end
    ett_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (cell_shift),
      .d_in  (cell_d),
      .q     (cell_q[k])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: if (idx_r == LAST_IDX) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    head_upd  = cell_q[0];
    found_nxt = found_r;
    first_nxt = first_r;
    ov_nxt    = 1'b0;
    kind_nxt  = KIND_STATUS;
    ok_nxt    = 1'b0;
    slot_nxt  = '0;
    id_nxt    = '0;
    ft_nxt    = '0;
    last_nxt  = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_SCAN: begin
        unique case (op_r)
          OP_REG: begin
            if (tag_nz && !found_r && cell_q[0].tag == '0) begin
              head_upd  = '{tag: tag_r, armed: 1'b0, due: '0, period: '0};
              found_nxt = 1'b1;
              first_nxt = idx_r;
            end
          end
          OP_UNREG: begin
            if (tag_nz && head_match) begin
              head_upd.tag   = '0;
              head_upd.armed = 1'b0;
              found_nxt      = 1'b1;
              if (!found_r) first_nxt = idx_r;
            end
          end
          OP_SCHED: begin
            if (tag_nz && time_nz && !found_r && head_match) begin
              head_upd.due    = time_r;
              head_upd.period = iv_r;
              head_upd.armed  = 1'b1;
              found_nxt       = 1'b1;
              first_nxt       = idx_r;
            end
          end
          OP_PROC: begin
            if (time_nz && head_due) begin
              ov_nxt   = 1'b1;
              kind_nxt = KIND_FIRED;
              ok_nxt   = 1'b1;
              slot_nxt = slot_code(idx_r);
              id_nxt   = cell_q[0].tag;
              ft_nxt   = cell_q[0].due;
              // advance a periodic slot, disarm a one-shot
              if (cell_q[0].period != '0) head_upd.due = cell_q[0].due + cell_q[0].period;
              else head_upd.armed = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ST_DONE: begin
        ov_nxt   = 1'b1;
        last_nxt = 1'b1;
        if (op_r == OP_PROC) begin
          kind_nxt = KIND_DONE;
          ok_nxt   = time_nz;
        end else begin
          kind_nxt = KIND_STATUS;
          ok_nxt   = found_r;
          slot_nxt = found_r ? slot_code(first_r) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ov_nxt;
      if (accept) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else if (cell_shift) begin
        idx_r   <= (idx_r == LAST_IDX) ? '0 : idx_r + CNT_W'(1);
        found_r <= found_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_op);
      tag_r  <= in_event_id;
      time_r <= in_time_req;
      iv_r   <= in_interval;
    end
    if (cell_shift) first_r <= first_nxt;
    out_kind_r <= kind_nxt;
    out_ok_r   <= ok_nxt;
    out_slot_r <= slot_nxt;
    out_id_r   <= id_nxt;
    out_ft_r   <= ft_nxt;
    out_last_r <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_ok        = out_ok_r;
  assign out_slot      = out_slot_r;
  assign out_fired_id  = out_id_r;
  assign out_fire_time = out_ft_r;
  assign out_last      = out_last_r;

  `ETT_ASSERT_SAME(a_fired_not_last, out_valid_r && out_kind_r == KIND_FIRED, !out_last_r)
  `ETT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ETT_ASSERT_NEXT(a_done_gives_last, state_r == ST_DONE, out_valid_r && out_last_r)
  `ETT_ASSERT_SAME(a_last_when_idle, out_valid_r && out_last_r, !busy)

endmodule
